### rtl/core/trial_division_prime_test_macros.svh
// assertion helpers used by the prime test rtl
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// property must hold at every edge outside reset
`define TDPT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tdpt assertion failed");

// consequent must hold in the cycle after the antecedent
`define TDPT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdpt next-cycle assertion failed");

`endif

### rtl/core/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int TDPT_VALUE_WIDTH   = 32;
   localparam int TDPT_QUEUE_DEPTH   = 2;
   localparam int TDPT_SMALLEST_PRIME = 2;
   localparam int TDPT_SMALL_LIMIT   = 4;
   localparam int TDPT_FIRST_DIVISOR = 3;

   // outcome of the front classification
   typedef struct packed {
      logic needs_trial;
      logic early_result;
   } tdpt_class_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_TEST,
      BK_DIV,
      BK_CHECK,
      BK_FINISH
   } tdpt_back_state_type;

endpackage

### rtl/core/tdpt_front.sv
// ----------------------------------------------------------------------------
// tdpt_front
// Accepts candidates, settles small and even values, pushes to the queue.
// ----------------------------------------------------------------------------
module tdpt_front #(
   parameter int VALUE_WIDTH = tdpt_pkg::TDPT_VALUE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [VALUE_WIDTH-1:0]     req_candidate,
   output logic                       push,
   input  logic                       q_full,
   output logic [VALUE_WIDTH-1:0]     push_value,
   output tdpt_pkg::tdpt_class_type   push_class
);
   import tdpt_pkg::*;

   logic                   vld_ff;
   logic                   vld_in;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic                   take;

   assign push      = vld_ff && !q_full;
   assign req_stall = vld_ff && q_full;
   assign take      = req_valid && !req_stall;
   assign vld_in    = take || (vld_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff <= req_candidate;
      end
   end

   // 0,1 -> not prime, 2,3 -> prime, other evens -> composite, odd rest -> trial
   always_comb begin
      push_class = '0;
      if (value_ff < VALUE_WIDTH'(TDPT_SMALLEST_PRIME)) begin
         push_class.early_result = 1'b0;
      end else if (value_ff < VALUE_WIDTH'(TDPT_SMALL_LIMIT)) begin
         push_class.early_result = 1'b1;
      end else if (!value_ff[0]) begin
         push_class.early_result = 1'b0;
      end else begin
         push_class.needs_trial = 1'b1;
      end
   end

   assign push_value = value_ff;

endmodule

### rtl/core/tdpt_queue.sv
// ----------------------------------------------------------------------------
// tdpt_queue
// Small fifo between the classifier and the divider loop.
// ----------------------------------------------------------------------------
module tdpt_queue #(
   parameter int VALUE_WIDTH = tdpt_pkg::TDPT_VALUE_WIDTH,
   parameter int DEPTH       = tdpt_pkg::TDPT_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [VALUE_WIDTH-1:0]     push_value,
   input  tdpt_pkg::tdpt_class_type   push_class,
   output logic                       q_full,
   input  logic                       pop,
   output logic                       q_valid,
   output logic [VALUE_WIDTH-1:0]     q_value,
   output tdpt_pkg::tdpt_class_type   q_class
);
   import tdpt_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [VALUE_WIDTH-1:0] value_ff [DEPTH];
   tdpt_class_type         class_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign q_valid = (count_ff != '0);
   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_value = value_ff[rd_ptr_ff];
   assign q_class = class_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         value_ff[wr_ptr_ff] <= push_value;
         class_ff[wr_ptr_ff] <= push_class;
      end
   end

endmodule

### rtl/core/tdpt_back.sv
// ----------------------------------------------------------------------------
// tdpt_back
// Trial divider loop with a bit-serial remainder unit and output register.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_macros.svh"

module tdpt_back #(
   parameter int VALUE_WIDTH = tdpt_pkg::TDPT_VALUE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  logic [VALUE_WIDTH-1:0]     q_value,
   input  tdpt_pkg::tdpt_class_type   q_class,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_is_prime
);
   import tdpt_pkg::*;

   // divisor never exceeds sqrt of the value plus two
   localparam int DW    = (VALUE_WIDTH + 1) / 2 + 1;
   localparam int SQ_W  = VALUE_WIDTH + 1;
   localparam int CNT_W = $clog2(VALUE_WIDTH);

   tdpt_back_state_type    state_ff, state_in;
   logic [VALUE_WIDTH-1:0] v_ff, v_in;
   logic [DW-1:0]          d_ff, d_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   res_ff, res_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic                   rsp_bit_ff, rsp_bit_in;
   logic                   out_free;
   logic                   load_out;
   logic                   out_bit;
   logic [DW:0]            shifted;
   logic                   rem_below_d;

   assign out_free    = !rsp_vld_ff || !rsp_stall;
   assign shifted     = {rem_ff, v_ff[cnt_ff]};
   assign rem_below_d = (rem_ff < d_ff);

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      d_in     = d_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      pop      = 1'b0;
      load_out = 1'b0;
      out_bit  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (!q_class.needs_trial) begin
                  if (out_free) begin
                     load_out = 1'b1;
                     out_bit  = q_class.early_result;
                     pop      = 1'b1;
                  end
               end else begin
                  pop      = 1'b1;
                  v_in     = q_value;
                  d_in     = DW'(TDPT_FIRST_DIVISOR);
                  sq_in    = SQ_W'(TDPT_FIRST_DIVISOR * TDPT_FIRST_DIVISOR);
                  state_in = BK_TEST;
               end
            end
         end
         BK_TEST: begin
            // stop once d*d passes the value
            if (sq_ff > {1'b0, v_ff}) begin
               res_in   = 1'b1;
               state_in = BK_FINISH;
            end else begin
               rem_in   = '0;
               cnt_in   = CNT_W'(VALUE_WIDTH - 1);
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            // restoring remainder, one value bit per cycle, msb first
            if (shifted >= {1'b0, d_ff}) begin
               rem_in = DW'(shifted - {1'b0, d_ff});
            end else begin
               rem_in = shifted[DW-1:0];
            end
            if (cnt_ff == '0) begin
               state_in = BK_CHECK;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         BK_CHECK: begin
            if (rem_ff == '0) begin
               res_in   = 1'b0;
               state_in = BK_FINISH;
            end else begin
               // (d+2)^2 = d^2 + 4d + 4
               d_in     = d_ff + DW'(2);
               sq_in    = sq_ff + SQ_W'({d_ff, 2'b00}) + SQ_W'(4);
               state_in = BK_TEST;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               load_out = 1'b1;
               out_bit  = res_ff;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_bit_in = rsp_bit_ff;
      if (load_out) begin
         rsp_vld_in = 1'b1;
         rsp_bit_in = out_bit;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      d_ff       <= d_in;
      sq_ff      <= sq_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      res_ff     <= res_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_is_prime = rsp_bit_ff;

   `TDPT_ASSERT(a_rem_below_divisor, clock, reset, (state_ff == BK_DIV) |-> rem_below_d)
   `TDPT_ASSERT(a_divisor_odd, clock, reset, (state_ff == BK_TEST) |-> (d_ff[0] && sq_ff[0]))
   `TDPT_ASSERT_NEXT(a_zero_rem_composite, clock, reset, (state_ff == BK_CHECK) && (rem_ff == '0), (state_ff == BK_FINISH) && !res_ff)
   `TDPT_ASSERT_NEXT(a_idle_after_result, clock, reset, (state_ff == BK_FINISH) && out_free, (state_ff == BK_IDLE) && rsp_vld_ff)

endmodule

### rtl/core/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test: 0..3 and even values are settled by the front classification
// odd values: trial division by odd divisors from 3 until one divides (composite) or d*d passes the value (prime)
// throughput: early values one per cycle while rsp_stall is low, otherwise one divide at a time
// reset: synchronous active high, clears control state, no clearing pass
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
   parameter int VALUE_WIDTH = tdpt_pkg::TDPT_VALUE_WIDTH,
   parameter int QUEUE_DEPTH = tdpt_pkg::TDPT_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_candidate,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_is_prime
);
   import tdpt_pkg::*;

   logic                   push;
   logic                   q_full;
   logic [VALUE_WIDTH-1:0] push_value;
   tdpt_class_type         push_class;
   logic                   pop;
   logic                   q_valid;
   logic [VALUE_WIDTH-1:0] q_value;
   tdpt_class_type         q_class;

   tdpt_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_candidate (req_candidate),
      .push          (push),
      .q_full        (q_full),
      .push_value    (push_value),
      .push_class    (push_class)
   );

   tdpt_queue #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DEPTH       (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (push_value),
      .push_class (push_class),
      .q_full     (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_value    (q_value),
      .q_class    (q_class)
   );

   tdpt_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_value      (q_value),
      .q_class      (q_class),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime)
   );

endmodule
